// ----- src/fct_pkg.sv -----
// Package for the frustum cull tester: command codes, fixed-point constants
// and the pipeline enable bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;
  localparam logic [1:0] CMD_LOAD_PLANE  = 2'd0;
  localparam logic [1:0] CMD_LOAD_CORNER = 2'd1;
  localparam logic [1:0] CMD_TEST_SPHERE = 2'd2;
  localparam logic [1:0] CMD_TEST_BOX    = 2'd3;

  localparam int FRAC_BITS   = 8;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_CORNERS = 8;
  localparam int SLOT_WIDTH  = 3;

  // stage advance strobes handed to the plane evaluators
  typedef struct packed {
    logic en2;
    logic en3;
  } fct_en_t;
endpackage
`default_nettype wire

// ----- src/fct_if.sv -----
// Valid/ready channel interfaces for the request and result streams.
// Depends on fct_pkg for the slot width.
`timescale 1ns / 1ps
`default_nettype none
interface fct_in_if import fct_pkg::*; #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [SLOT_WIDTH-1:0]         slot;
  logic signed [COORD_WIDTH-1:0] p_x, p_y, p_z;
  logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z;
  logic signed [COORD_WIDTH-1:0] extra;
  modport source (output valid, command, slot, p_x, p_y, p_z, q_x, q_y, q_z, extra,
                  input ready);
  modport sink (input valid, command, slot, p_x, p_y, p_z, q_x, q_y, q_z, extra,
                output ready);
endinterface

interface fct_out_if;
  logic valid;
  logic ready;
  logic visible;
  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

// ----- src/fct_plane_eval.sv -----
// One plane against the eight box corners: products, then signed distances.
// Two register stages; depends on fct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fct_plane_eval import fct_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  fct_en_t                            en,
  input  wire logic signed [COORD_WIDTH-1:0] n_x, n_y, n_z,
  input  wire logic signed [COORD_WIDTH:0]   offset,
  input  wire logic signed [COORD_WIDTH-1:0] p_x, p_y, p_z,
  input  wire logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z,
  output logic [NUM_CORNERS-1:0]             neg_r
);
  localparam int PW = 2 * COORD_WIDTH;
  localparam int SW = (2 * COORD_WIDTH + 3 > 64) ? 64 : 2 * COORD_WIDTH + 3;

  logic signed [PW-1:0] pxm_r, pym_r, pzm_r, qxm_r, qym_r, qzm_r;
  logic signed [COORD_WIDTH:0] off_r;
  logic [NUM_CORNERS-1:0] neg_nxt;

  // stage 2: the six per-axis products
  always_ff @(posedge clk) begin
    if (en.en2) begin
      pxm_r <= n_x * p_x;
      pym_r <= n_y * p_y;
      pzm_r <= n_z * p_z;
      qxm_r <= n_x * q_x;
      qym_r <= n_y * q_y;
      qzm_r <= n_z * q_z;
      off_r <= offset;
    end
  end

  // stage 3: sign of each corner distance; corner bit k picks max on that axis
  always_comb begin
    logic signed [SW-1:0] s;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      s = SW'(k[0] ? qxm_r : pxm_r) + SW'(k[1] ? qym_r : pym_r)
        + SW'(k[2] ? qzm_r : pzm_r) + (SW'(off_r) <<< FRAC_BITS);
      neg_nxt[k] = s[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en3) neg_r <= neg_nxt;
  end
endmodule
`default_nettype wire

// ----- src/frustum_cull_tester.sv -----
// Frustum cull tester top level: plane/corner store, containment check and
// the four-stage pipeline. Depends on fct_pkg, fct_if and fct_plane_eval.
// A test request passes stage 1, stage 2, stage 3 and the output register.
// Throughput: one request per cycle unless out_ch.ready back-pressures; load requests give no result.
// Each stage has its own valid bit and advances when its successor has room.
// Reset (rst_n, synchronous, active low) clears the valid bits only;
// planes and corners are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module frustum_cull_tester import fct_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  fct_in_if.sink   in_ch,
  fct_out_if.source out_ch
);
  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] pl_nx_r [NUM_PLANES];
  logic signed [W-1:0] pl_ny_r [NUM_PLANES];
  logic signed [W-1:0] pl_nz_r [NUM_PLANES];
  logic signed [W-1:0] pl_d_r  [NUM_PLANES];
  logic signed [W-1:0] co_x_r  [NUM_CORNERS];
  logic signed [W-1:0] co_y_r  [NUM_CORNERS];
  logic signed [W-1:0] co_z_r  [NUM_CORNERS];

  logic v1_r, v2_r, v3_r, ov_r;
  logic en1, en2, en3, eno;
  logic sph1_r, sph2_r, sph3_r;
  logic signed [W-1:0] px_r, py_r, pz_r, qx_r, qy_r, qz_r, ex_r;
  logic [NUM_CORNERS-1:0] in_nxt, in2_r, in3_r;
  logic [NUM_CORNERS-1:0] neg [NUM_PLANES];
  logic vis_nxt, vis_r;
  logic acc;
  fct_en_t en;

  // stage handshake
  assign eno = !ov_r || out_ch.ready;
  assign en3 = !v3_r || eno;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en  = '{en2: en2, en3: en3};
  assign in_ch.ready = en1;
  assign acc = in_ch.valid && en1;

  // load requests write the store at acceptance
  always_ff @(posedge clk) begin
    if (acc && in_ch.command == CMD_LOAD_PLANE && in_ch.slot < SLOT_WIDTH'(NUM_PLANES)) begin
      pl_nx_r[in_ch.slot] <= in_ch.p_x;
      pl_ny_r[in_ch.slot] <= in_ch.p_y;
      pl_nz_r[in_ch.slot] <= in_ch.p_z;
      pl_d_r[in_ch.slot]  <= in_ch.extra;
    end
    if (acc && in_ch.command == CMD_LOAD_CORNER) begin
      co_x_r[in_ch.slot] <= in_ch.p_x;
      co_y_r[in_ch.slot] <= in_ch.p_y;
      co_z_r[in_ch.slot] <= in_ch.p_z;
    end
  end

  // valid bits: only test requests enter the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid &&
                       (in_ch.command inside {CMD_TEST_SPHERE, CMD_TEST_BOX});
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (eno) ov_r <= v3_r;
    end
  end

  // stage 1: capture the volume
  always_ff @(posedge clk) begin
    if (en1) begin
      sph1_r <= in_ch.command == CMD_TEST_SPHERE;
      px_r <= in_ch.p_x;
      py_r <= in_ch.p_y;
      pz_r <= in_ch.p_z;
      qx_r <= in_ch.q_x;
      qy_r <= in_ch.q_y;
      qz_r <= in_ch.q_z;
      ex_r <= in_ch.extra;
    end
  end

  // frustum corners inside the box
  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      in_nxt[i] = co_x_r[i] >= px_r && co_x_r[i] <= qx_r &&
                  co_y_r[i] >= py_r && co_y_r[i] <= qy_r &&
                  co_z_r[i] >= pz_r && co_z_r[i] <= qz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sph2_r <= sph1_r;
      in2_r  <= in_nxt;
    end
    if (en3) begin
      sph3_r <= sph2_r;
      in3_r  <= in2_r;
    end
  end

  // per-plane distance evaluators; sphere radius folds into the offset
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
    logic signed [W:0] off;
    assign off = (sph1_r ? (W+1)'(ex_r) : (W+1)'(0)) - (W+1)'(pl_d_r[g]);
    fct_plane_eval #(.COORD_WIDTH(W)) u_eval (
      .clk(clk), .en(en),
      .n_x(pl_nx_r[g]), .n_y(pl_ny_r[g]), .n_z(pl_nz_r[g]), .offset(off),
      .p_x(px_r), .p_y(py_r), .p_z(pz_r), .q_x(qx_r), .q_y(qy_r), .q_z(qz_r),
      .neg_r(neg[g])
    );
  end

  // final verdict: sphere uses the centre only (corner 0 is all-min)
  always_comb begin
    logic [NUM_CORNERS-1:0] anyneg;
    anyneg = '0;
    for (int j = 0; j < NUM_PLANES; j++) anyneg = anyneg | neg[j];
    if (sph3_r) vis_nxt = !anyneg[0];
    else        vis_nxt = (~anyneg != '0) || (in3_r != '0);
  end

  always_ff @(posedge clk) begin
    if (eno) vis_r <= vis_nxt;
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.visible = vis_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> (v1_r && $stable(px_r) && $stable(sph1_r)))
    else $error("stage 1 request lost during stall");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.visible)))
    else $error("result dropped while waiting");
`endif
endmodule
`default_nettype wire
